### hdl/hts_pkg.sv
// shared types, character codes and entity tables for the html tag stripper
// no dependencies; imported by every other file of the block
package hts_pkg;

  localparam int NENT   = 7;
  localparam int HOLD_N = 5;
  localparam int QB     = 8 * HOLD_N;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hts_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } hts_state_t;

  // entity text, byte i at bits [8*i +: 8]
  function automatic logic [47:0] ent_word(input logic [2:0] k);
    case (k)
      3'd0:    return 48'h003B706D6126;
      3'd1:    return 48'h00003B746C26;
      3'd2:    return 48'h00003B746726;
      3'd3:    return 48'h3B746F757126;
      3'd4:    return 48'h3B736F706126;
      3'd5:    return 48'h003B39332326;
      3'd6:    return 48'h3B7073626E26;
      default: return 48'h0;
    endcase
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] k);
    case (k)
      3'd0:    return 3'd5;
      3'd1:    return 3'd4;
      3'd2:    return 3'd4;
      3'd3:    return 3'd6;
      3'd4:    return 3'd6;
      3'd5:    return 3'd5;
      3'd6:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] k);
    case (k)
      3'd0:    return CH_AMP;
      3'd1:    return CH_LT;
      3'd2:    return CH_GT;
      3'd3:    return 8'h22;
      3'd4:    return 8'h27;
      3'd5:    return 8'h27;
      3'd6:    return CH_SP;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### hdl/hts_front.sv
// front end: accepts input requests and queues them for the back end
// depends on hts_pkg
module hts_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  output logic              q_valid,
  output hts_pkg::hts_item_t q_item,
  input  logic              q_pop
);
  import hts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hts_item_t       fifo_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_tready = (cnt_r != CW'(DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{data: in_tdata, last: in_tlast};
    end
  end

endmodule

### hdl/hts_back.sv
// back end: tag dropping, entity decode with replay, space collapsing, output register
// depends on hts_pkg
module hts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hts_pkg::hts_item_t q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic [0:0]         out_tuser,
  output logic               out_tlast
);
  import hts_pkg::*;

  hts_state_t    state_r, state_nxt;
  logic [QB-1:0] rq_r, rq_nxt;
  logic [2:0]    rq_len_r, rq_len_nxt;
  logic [QB-1:0] hold_r, hold_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          inside_r, inside_nxt;
  logic          seen_r, seen_nxt;
  logic          spc_r, spc_nxt;
  logic          last_r, last_nxt;
  logic          stg_valid_r, stg_valid_nxt;
  logic [7:0]    stg_data_r, stg_data_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    od_r, od_nxt;
  logic          ou_r, ou_nxt;
  logic          ol_r, ol_nxt;

  logic [7:0]      b;
  logic [NENT-1:0] hit, comp;
  logic [7:0]      comp_ch;
  logic [47:0]     word, sel;
  logic            ok;
  logic            run_feed, run_flush, run_end, end_go, out_free;

  logic [2:0]    nm1, off, rest_len, rq_rq_len;
  logic          extra;
  logic [QB-1:0] keep_mask, part_a, part_b, part_c, rq_rq;

  logic [QB-1:0] p_rq, p_hold;
  logic [2:0]    p_rq_len, p_cnt;
  logic          p_inside;
  logic          emit_req;
  logic [7:0]    emit_ch;

  logic          need, want_res, redo, stall;
  logic [7:0]    res_ch;

  assign b         = rq_r[7:0];
  assign run_feed  = (state_r == ST_RUN) && (rq_len_r != 3'd0);
  assign run_flush = (state_r == ST_RUN) && (rq_len_r == 3'd0) && last_r && (cnt_r != 3'd0);
  assign run_end   = (state_r == ST_RUN) && (rq_len_r == 3'd0) && !(last_r && (cnt_r != 3'd0));
  assign out_free  = !ov_r || out_tready;

  // entity candidates against the held bytes and the next byte
  always_comb begin
    hit     = '0;
    comp    = '0;
    comp_ch = 8'h00;
    word    = '0;
    sel     = '0;
    ok      = 1'b0;
    for (int k = 0; k < NENT; k++) begin
      word = ent_word(3'(k));
      sel  = word >> {cnt_r, 3'b000};
      ok   = (({1'b0, cnt_r} + 4'd1) <= {1'b0, ent_len(3'(k))}) && (sel[7:0] == b);
      for (int i = 0; i < HOLD_N; i++) begin
        if (3'(i) < cnt_r) begin
          ok = ok && (hold_r[8*i +: 8] == word[8*i +: 8]);
        end
      end
      hit[k]  = ok;
      comp[k] = ok && (({1'b0, cnt_r} + 4'd1) == {1'b0, ent_len(3'(k))});
    end
    for (int k = NENT - 1; k >= 0; k--) begin
      if (comp[k]) begin
        comp_ch = ent_char(3'(k));
      end
    end
  end

  // held bytes after the ampersand, then any failing byte, then the rest of the replay queue
  always_comb begin
    extra     = run_feed;
    nm1       = cnt_r - 3'd1;
    off       = nm1 + {2'b00, extra};
    rest_len  = extra ? (rq_len_r - 3'd1) : 3'd0;
    keep_mask = (QB'(1) << {nm1, 3'b000}) - QB'(1);
    part_a    = {8'h00, hold_r[QB-1:8]} & keep_mask;
    part_b    = extra ? (QB'(b) << {nm1, 3'b000}) : '0;
    part_c    = {8'h00, rq_r[QB-1:8]} << {off, 3'b000};
    rq_rq     = part_a | part_b | part_c;
    rq_rq_len = off + rest_len;
  end

  // byte decode
  always_comb begin
    p_rq     = {8'h00, rq_r[QB-1:8]};
    p_rq_len = rq_len_r - 3'd1;
    p_hold   = hold_r;
    p_cnt    = cnt_r;
    p_inside = inside_r;
    emit_req = 1'b0;
    emit_ch  = b;
    if (run_flush) begin
      p_cnt    = 3'd0;
      emit_req = 1'b1;
      emit_ch  = CH_AMP;
      p_rq     = rq_rq;
      p_rq_len = rq_rq_len;
    end else if (cnt_r != 3'd0) begin
      if (|comp) begin
        p_cnt    = 3'd0;
        emit_req = 1'b1;
        emit_ch  = comp_ch;
      end else if ((|hit) && (cnt_r < 3'(HOLD_N))) begin
        p_hold[{cnt_r, 3'b000} +: 8] = b;
        p_cnt = cnt_r + 3'd1;
      end else begin
        p_cnt    = 3'd0;
        emit_req = 1'b1;
        emit_ch  = CH_AMP;
        p_rq     = rq_rq;
        p_rq_len = rq_rq_len;
      end
    end else if (b == CH_LT) begin
      p_inside = 1'b1;
    end else if (b == CH_GT) begin
      p_inside = 1'b0;
      emit_req = 1'b1;
      emit_ch  = CH_SP;
    end else if (inside_r) begin
      p_inside = 1'b1;
    end else if (b == CH_AMP) begin
      p_hold[7:0] = CH_AMP;
      p_cnt       = 3'd1;
    end else begin
      emit_req = 1'b1;
    end
  end

  // datapath and output register updates
  always_comb begin
    rq_nxt        = rq_r;
    rq_len_nxt    = rq_len_r;
    hold_nxt      = hold_r;
    cnt_nxt       = cnt_r;
    inside_nxt    = inside_r;
    seen_nxt      = seen_r;
    spc_nxt       = spc_r;
    last_nxt      = last_r;
    stg_valid_nxt = stg_valid_r;
    stg_data_nxt  = stg_data_r;
    ov_nxt        = ov_r && !out_tready;
    od_nxt        = od_r;
    ou_nxt        = ou_r;
    ol_nxt        = ol_r;
    q_pop         = 1'b0;
    end_go        = 1'b0;
    need          = 1'b0;
    want_res      = 1'b0;
    redo          = 1'b0;
    stall         = 1'b0;
    res_ch        = emit_ch;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rq_nxt     = {{(QB-8){1'b0}}, q_item.data};
          rq_len_nxt = 3'd1;
          last_nxt   = q_item.last;
        end
      end
      ST_RUN: begin
        if (run_end) begin
          need = last_r || stg_valid_r;
          if (!need || out_free) begin
            if (need) begin
              ov_nxt = 1'b1;
              od_nxt = stg_valid_r ? stg_data_r : 8'h00;
              ou_nxt = stg_valid_r;
              ol_nxt = last_r;
            end
            stg_valid_nxt = 1'b0;
            if (last_r) begin
              inside_nxt = 1'b0;
              seen_nxt   = 1'b0;
              spc_nxt    = 1'b0;
              cnt_nxt    = 3'd0;
            end
            end_go = 1'b1;
            if (q_valid) begin
              q_pop      = 1'b1;
              rq_nxt     = {{(QB-8){1'b0}}, q_item.data};
              rq_len_nxt = 3'd1;
              last_nxt   = q_item.last;
            end
          end
        end else begin
          if (emit_req && !is_ws(emit_ch)) begin
            want_res = 1'b1;
            redo     = spc_r;
            res_ch   = spc_r ? CH_SP : emit_ch;
          end
          stall = want_res && stg_valid_r && !out_free;
          if (!stall) begin
            if (want_res) begin
              if (stg_valid_r) begin
                ov_nxt = 1'b1;
                od_nxt = stg_data_r;
                ou_nxt = 1'b1;
                ol_nxt = 1'b0;
              end
              stg_valid_nxt = 1'b1;
              stg_data_nxt  = res_ch;
            end
            if (redo) begin
              spc_nxt = 1'b0;
            end else begin
              rq_nxt     = p_rq;
              rq_len_nxt = p_rq_len;
              hold_nxt   = p_hold;
              cnt_nxt    = p_cnt;
              inside_nxt = p_inside;
              if (want_res) begin
                seen_nxt = 1'b1;
                spc_nxt  = 1'b0;
              end else if (emit_req && seen_r) begin
                spc_nxt = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = q_valid ? ST_RUN : ST_IDLE;
      ST_RUN:  state_nxt = (end_go && !q_valid) ? ST_IDLE : ST_RUN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rq_len_r    <= 3'd0;
      cnt_r       <= 3'd0;
      inside_r    <= 1'b0;
      seen_r      <= 1'b0;
      spc_r       <= 1'b0;
      last_r      <= 1'b0;
      stg_valid_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rq_len_r    <= rq_len_nxt;
      cnt_r       <= cnt_nxt;
      inside_r    <= inside_nxt;
      seen_r      <= seen_nxt;
      spc_r       <= spc_nxt;
      last_r      <= last_nxt;
      stg_valid_r <= stg_valid_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rq_r       <= rq_nxt;
    hold_r     <= hold_nxt;
    stg_data_r <= stg_data_nxt;
    od_r       <= od_nxt;
    ou_r       <= ou_nxt;
    ol_r       <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule

### hdl/html_tag_stripper_core.sv
// top level of the html tag stripper: input queue in front, decode engine behind
// depends on hts_pkg, hts_front, hts_back
//
// channel | direction | tdata        | tuser      | tlast
// in_     | slave     | in_byte[7:0] | -          | in_last
// out_    | master    | out_byte     | byte_valid | out_last
//
// in the engine a plain byte is first decoded, then its request is closed and the next
// is taken; an idle engine picks up a request in a step of its own before that
// a collapsed space written before a byte adds a step of its own, as does the ampersand of
// an entity left open at the end of a text; each replayed byte takes a step of its own
// reset is synchronous, active low, and leaves the block empty and ready
// the input queue keeps taking requests while the engine or the output stalls, until full
module html_tag_stripper_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] byte_valid
  output logic       out_tlast
);
  import hts_pkg::*;

  logic      q_valid;
  hts_item_t q_item;
  logic      q_pop;

  hts_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  hts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### hdl/hts_checker.sv
// port-level checks on the result channel of the html tag stripper
// depends on hts_pkg; bound to html_tag_stripper_core
module hts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);
  import hts_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 8'h00))
    else $error("bare marker not final or not zero");

  a_ws_collapsed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata != CH_TAB) && (out_tdata != CH_CR) && (out_tdata != CH_LF))
    else $error("uncollapsed white space");

  a_no_trailing_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tlast |-> out_tdata != CH_SP)
    else $error("trailing space on final result");

endmodule

bind html_tag_stripper_core hts_checker u_hts_checker (.*);

### dv/html_tag_stripper_core_test.sv
`timescale 1ns / 100ps
// self-checking bench for html_tag_stripper_core: tag stripping, entity decoding and space
// collapsing, with a directed table then random texts, checked against an in-bench predictor
// depends on hts_pkg (character codes) and the html_tag_stripper_core rtl
module html_tag_stripper_core_test;
  import hts_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } text_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    text_res_t  r;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_OFF     = 150;
  localparam int DRAIN_CYCLES = 60;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic       out_tlast;

  // predictor state
  logic       in_tag;
  logic [7:0] amp_hold [5];
  int         amp_cnt;
  logic       text_seen;
  logic       gap_pending;
  logic [7:0] replay_q [$];
  text_res_t  step_res [$];
  text_res_t  text_exp [$];

  // driver side
  logic       row_typed;
  text_res_t  row_res;
  stim_row_t  dir_rows [26];
  logic [7:0] text_buf [$];
  bit         send_calm;
  bit         take_calm;
  bit         squeeze_req;
  int         random_sent;

  int mismatches;
  int requests;
  int results;
  int markers;
  int texts;
  int held_cycles;

  html_tag_stripper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still awaited", text_exp.size());
    $display("html_tag_stripper_core_test: errors");
    $finish;
  end

  function automatic string entity_text(int k);
    case (k)
      0:       return "&amp;";
      1:       return "&lt;";
      2:       return "&gt;";
      3:       return "&quot;";
      4:       return "&apos;";
      5:       return "&#39;";
      default: return "&nbsp;";
    endcase
  endfunction

  function automatic logic [7:0] entity_char(int k);
    case (k)
      0:       return CH_AMP;
      1:       return CH_LT;
      2:       return CH_GT;
      3:       return 8'h22;
      4:       return 8'h27;
      5:       return 8'h27;
      default: return CH_SP;
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic void strip_clear();
    in_tag      = 1'b0;
    amp_cnt     = 0;
    text_seen   = 1'b0;
    gap_pending = 1'b0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    if (is_blank(c)) begin
      if (text_seen) gap_pending = 1'b1;
      return;
    end
    if (gap_pending) step_res.insert(step_res.size(), text_res_t'{CH_SP, 1'b1, 1'b0});
    step_res.insert(step_res.size(), text_res_t'{c, 1'b1, 1'b0});
    text_seen   = 1'b1;
    gap_pending = 1'b0;
  endfunction

  // held bytes after the ampersand, then any breaking byte, go back in front of the queue
  function automatic void replay_held(int n, bit with_b, logic [7:0] b);
    logic [7:0] front [$];
    for (int i = 1; i < n; i++) front.insert(front.size(), amp_hold[i]);
    if (with_b) front.insert(front.size(), b);
    replay_q = {front, replay_q};
  endfunction

  function automatic void feed_byte(logic [7:0] b);
    string e;
    bit    partial;
    bit    same;
    int    n;
    partial = 1'b0;
    if (amp_cnt != 0) begin
      n = amp_cnt;
      for (int k = 0; k < 7; k++) begin
        e    = entity_text(k);
        same = 1'b1;
        for (int i = 0; i < n; i++) if (amp_hold[i] != e[i]) same = 1'b0;
        if (n + 1 <= e.len() && same && e[n] == b) begin
          if (n + 1 == e.len()) begin
            amp_cnt = 0;
            put_char(entity_char(k));
            return;
          end
          partial = 1'b1;
        end
      end
      if (partial && n < 5) begin
        amp_hold[n] = b;
        amp_cnt     = n + 1;
        return;
      end
      amp_cnt = 0;
      put_char(CH_AMP);
      replay_held(n, 1'b1, b);
      return;
    end
    if (b == CH_LT) begin
      in_tag = 1'b1;
      return;
    end
    if (b == CH_GT) begin
      in_tag = 1'b0;
      put_char(CH_SP);
      return;
    end
    if (in_tag) return;
    if (b == CH_AMP) begin
      amp_hold[0] = CH_AMP;
      amp_cnt     = 1;
      return;
    end
    put_char(b);
  endfunction

  function automatic void drain_replay();
    while (replay_q.size() > 0) feed_byte(replay_q.pop_front());
  endfunction

  function automatic void predict_step(logic [7:0] b, logic l);
    int n;
    step_res.delete();
    replay_q.delete();
    replay_q.insert(0, b);
    drain_replay();
    if (l) begin
      while (amp_cnt != 0) begin
        n       = amp_cnt;
        amp_cnt = 0;
        put_char(CH_AMP);
        replay_q.delete();
        replay_held(n, 1'b0, 8'h00);
        drain_replay();
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      else step_res.insert(0, text_res_t'{8'h00, 1'b0, 1'b1});
      strip_clear();
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    text_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        requests++;
        if (in_tlast) texts++;
        predict_step(in_tdata, in_tlast);
        if (row_typed) begin
          if (step_res.size() != 1 || step_res[0] != row_res)
            report_mismatch($sformatf("predictor disagrees with table on request %h", in_tdata));
          text_exp.insert(text_exp.size(), row_res);
        end else begin
          foreach (step_res[i]) text_exp.insert(text_exp.size(), step_res[i]);
        end
      end
      if (out_tvalid && out_tready) begin
        results++;
        if (!out_tuser[0]) markers++;
        if (text_exp.size() == 0) begin
          report_mismatch($sformatf("result %h/%b/%b with nothing awaited",
                                    out_tdata, out_tuser[0], out_tlast));
        end else begin
          want = text_exp.pop_front();
          if (out_tdata !== want.data || out_tuser[0] !== want.valid ||
              out_tlast !== want.last)
            report_mismatch($sformatf("got byte %h valid %b last %b, want %h %b %b",
                                      out_tdata, out_tuser[0], out_tlast,
                                      want.data, want.valid, want.last));
        end
      end
    end
  end

  // a random wait, with calm stretches of no waiting at all
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 9) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_request(input logic [7:0] b, input logic l, input logic typed,
                              input text_res_t r);
    int gap;
    gap = draw_wait(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = l;
    row_typed = typed;
    row_res   = r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait(take_calm);
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_tready  = 1'b0;
        repeat (HOLD_OFF) begin
          @(negedge clk);
          held_cycles++;
        end
      end else if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic stim_row_t row(logic [7:0] b, logic l, logic typed,
                                    logic [7:0] d, logic v, logic t);
    return {b, l, typed, d, v, t};
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // one random piece of text: mostly well formed, some broken entities and raw noise
  function automatic void add_piece();
    int         kind;
    int         cnt;
    string      e;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      cnt = $urandom_range(1, 6);
      repeat (cnt) text_buf.insert(text_buf.size(), 8'($urandom_range(8'h61, 8'h7A)));
    end else if (kind < 42) begin
      cnt = $urandom_range(1, 3);
      repeat (cnt) begin
        case ($urandom_range(0, 3))
          0:       text_buf.insert(text_buf.size(), CH_SP);
          1:       text_buf.insert(text_buf.size(), CH_TAB);
          2:       text_buf.insert(text_buf.size(), CH_CR);
          default: text_buf.insert(text_buf.size(), CH_LF);
        endcase
      end
    end else if (kind < 56) begin
      text_buf.insert(text_buf.size(), CH_LT);
      cnt = $urandom_range(0, 5);
      repeat (cnt) begin
        c = printable();
        if (c == CH_GT) c = CH_AMP;
        text_buf.insert(text_buf.size(), c);
      end
      text_buf.insert(text_buf.size(), CH_GT);
    end else if (kind < 72) begin
      e = entity_text($urandom_range(0, 6));
      for (int i = 0; i < e.len(); i++) text_buf.insert(text_buf.size(), e[i]);
    end else if (kind < 86) begin
      e   = entity_text($urandom_range(0, 6));
      cnt = $urandom_range(1, e.len() - 1);
      for (int i = 0; i < cnt; i++) text_buf.insert(text_buf.size(), e[i]);
      if ($urandom_range(0, 1)) text_buf.insert(text_buf.size(), printable());
    end else if (kind < 95) begin
      text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
    end else begin
      text_buf.insert(text_buf.size(), CH_GT);
    end
  endfunction

  initial begin
    int    pieces;
    int    cut;
    string e;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    row_typed   = 1'b0;
    row_res     = '0;
    squeeze_req = 1'b0;
    send_calm   = 1'b0;
    take_calm   = 1'b0;
    random_sent = 0;
    mismatches  = 0;
    requests    = 0;
    results     = 0;
    markers     = 0;
    texts       = 0;
    held_cycles = 0;
    strip_clear();
    dir_rows = '{
      row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1),
      row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0),
      row(" ",   1'b1, 1'b1, 8'h00, 1'b0, 1'b1),
      row(">",   1'b1, 1'b1, 8'h00, 1'b0, 1'b1),
      row("<",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("<",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row(">",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("a",   1'b0, 1'b1, "a",   1'b1, 1'b0),
      row("\t",  1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("l",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("t",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row(";",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("#",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("3",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("9",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row(";",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("q",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("x",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      row("a",   1'b1, 1'b0, 8'h00, 1'b0, 1'b0),
      row("\n",  1'b1, 1'b1, 8'h00, 1'b0, 1'b1)
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].r);

    squeeze_req = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      text_buf.delete();
      pieces = $urandom_range(1, 8);
      repeat (pieces) add_piece();
      // now and then the text ends on an unfinished entity
      if ($urandom_range(0, 4) == 0) begin
        e   = entity_text($urandom_range(0, 6));
        cut = $urandom_range(1, e.len() - 1);
        for (int i = 0; i < cut; i++) text_buf.insert(text_buf.size(), e[i]);
      end
      foreach (text_buf[i]) begin
        send_request(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
        random_sent++;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;

    while (text_exp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d texts in %0d requests gave %0d results, %0d of them bare end markers",
             texts, requests, results, markers);
    $display("tags, all seven entities, broken entities, space runs, %0d-cycle hold-off",
             held_cycles);
    if (mismatches == 0) begin
      $display("html_tag_stripper_core_test: clean");
    end else begin
      $display("html_tag_stripper_core_test: errors");
    end
    $finish;
  end

endmodule
